[rtl/sgt_pkg.sv]
// sgt_pkg: shared types, constants and saturation helper for the grid transfer unit
// depends on nothing; used by every module in rtl except sgt_ram
`default_nettype none

package sgt_pkg;

  // coarse vector storage
  localparam int COARSE_ENTRIES = 4096;
  localparam int ADDR_W         = $clog2(COARSE_ENTRIES);

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // weight (17 bits unsigned) times q16.16 value, magnitude below 2^48
  localparam int PROD_W = 49;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_PROLONG  = 2'd1,
    OP_RESTRICT = 2'd2,
    OP_READ     = 2'd3
  } opcode_t;

  typedef enum logic {
    KIND_FINE   = 1'b0,
    KIND_COARSE = 1'b1
  } kind_t;

  // incoming transaction
  typedef struct packed {
    logic [1:0]         opcode;
    logic [11:0]        coarse_index;
    logic [16:0]        weight;
    logic signed [31:0] data_value;
    logic               last_of_row;
  } in_item_t;

  // outgoing transaction
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_kind;
    logic               saturated;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    opcode_t            op;
    logic [ADDR_W-1:0]  addr;
    logic               in_range;
    logic               writes;
    logic [16:0]        weight;
    logic signed [31:0] data;
    logic               last;
  } q_entry_t;

  // queue fill status
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_status_t;

  // clip to signed 32 bits, msb of the result flags a clip
  function automatic logic [32:0] sat32(input logic signed [33:0] v);
    logic [32:0] r;
    if (v > 34'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -34'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sgt_ram.sv]
// sgt_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sgt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/sgt_front.sv]
// sgt_front: accepts input transactions and classifies them for the queue
// depends on sgt_pkg
`default_nettype none

module sgt_front (
  input  wire logic             item_valid,
  input  wire sgt_pkg::in_item_t item,
  input  wire logic             full,
  output logic                  item_stall,
  output logic                  push,
  output sgt_pkg::q_entry_t     entry
);

  sgt_pkg::opcode_t op;
  logic             in_range;

  // decode
  assign op       = sgt_pkg::opcode_t'(item.opcode);
  assign in_range = 32'(item.coarse_index) < 32'(sgt_pkg::COARSE_ENTRIES);

  // handshake, held off while the queue is full
  assign item_stall = full;
  assign push       = item_valid && !full;

  // classified entry
  always_comb begin
    entry          = '0;
    entry.op       = op;
    entry.addr     = sgt_pkg::ADDR_W'(item.coarse_index);
    entry.in_range = in_range;
    entry.writes   = in_range && (op == sgt_pkg::OP_WRITE || op == sgt_pkg::OP_RESTRICT);
    entry.weight   = item.weight;
    entry.data     = item.data_value;
    entry.last     = item.last_of_row && (op == sgt_pkg::OP_PROLONG);
  end

endmodule

`default_nettype wire

[rtl/sgt_queue.sv]
// sgt_queue: short fifo of classified items between front and back
// depends on sgt_pkg
`default_nettype none

module sgt_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sgt_pkg::q_entry_t entry_in,
  input  wire logic              pop,
  output sgt_pkg::q_entry_t      head,
  output sgt_pkg::q_status_t     status
);

  sgt_pkg::q_entry_t              slots [sgt_pkg::QUEUE_DEPTH];
  logic [sgt_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sgt_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sgt_pkg::QCNT_W-1:0]     count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.count = count;
  assign status.full  = count == sgt_pkg::QCNT_W'(sgt_pkg::QUEUE_DEPTH);
  assign status.empty = count == '0;

endmodule

`default_nettype wire

[rtl/sgt_back.sv]
// sgt_back: execution pipeline with coarse vector ram, multiplier, accumulator
// and output register; depends on sgt_pkg and sgt_ram
`default_nettype none

module sgt_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire sgt_pkg::q_entry_t head,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output sgt_pkg::out_item_t     result
);

  logic adv;

  // stage 1: ram data arrives, multiply
  logic                      v1;
  sgt_pkg::q_entry_t         e1;
  logic                      byp1;
  logic signed [31:0]        bypv1;
  logic signed [31:0]        ram_rdata;
  logic signed [31:0]        c1;
  logic signed [31:0]        mul_b;
  logic signed [49:0]        mul_full;

  // stage 2: round and clip the product
  logic                              v2;
  sgt_pkg::q_entry_t                 e2;
  logic signed [sgt_pkg::PROD_W-1:0] p2;
  logic signed [31:0]                c2;
  logic signed [sgt_pkg::PROD_W-1:0] p2_rnd;
  logic [32:0]                       prod_sat;

  // stage 3: accumulate or read-modify-write
  logic               v3;
  sgt_pkg::q_entry_t  e3;
  logic signed [31:0] prod3;
  logic               psat3;
  logic signed [31:0] c3;
  logic signed [31:0] addend;
  logic [32:0]        sum_sat;
  logic               s3_wr;
  logic signed [31:0] s3_wdata;
  logic signed [31:0] acc;
  logic               rsat;
  logic               row_flag;

  // stage 4: row end values before the final add
  logic               v4;
  sgt_pkg::kind_t     k4;
  logic signed [31:0] d4;
  logic signed [31:0] a4;
  logic               f4;
  logic signed [31:0] c4;
  logic [32:0]        fin_sat;

  logic hazard;

  // whole pipeline moves when the output register can take a transaction
  assign adv = !result_valid || !result_stall;

  // prolongation reads the coarse entry early: wait for pending writes to it
  assign hazard = head.op == sgt_pkg::OP_PROLONG && head.in_range &&
                  ((v1 && e1.writes && e1.addr == head.addr) ||
                   (v2 && e2.writes && e2.addr == head.addr));
  assign pop = adv && head_valid && !hazard;

  // coarse vector
  sgt_ram #(
    .WIDTH (32),
    .DEPTH (sgt_pkg::COARSE_ENTRIES)
  ) u_coarse (
    .clk   (clk),
    .we    (s3_wr),
    .waddr (e3.addr),
    .wdata (s3_wdata),
    .re    (adv),
    .raddr (head.addr),
    .rdata (ram_rdata)
  );

  // stage 1 operand selection and multiply
  assign c1       = !e1.in_range ? 32'sd0 : (byp1 ? bypv1 : ram_rdata);
  assign mul_b    = (e1.op == sgt_pkg::OP_PROLONG) ? c1 : e1.data;
  assign mul_full = 50'($signed({1'b0, e1.weight})) * 50'(mul_b);

  // stage 2 rounding, ties towards plus infinity
  assign p2_rnd   = p2 + 49'sd32768;
  assign prod_sat = sgt_pkg::sat32(34'($signed(p2_rnd[sgt_pkg::PROD_W-1:16])));

  // stage 3 add and clip
  assign addend   = (e3.op == sgt_pkg::OP_PROLONG) ? acc : c3;
  assign sum_sat  = sgt_pkg::sat32(34'(addend) + 34'(prod3));
  assign s3_wr    = v3 && adv && e3.writes;
  assign s3_wdata = (e3.op == sgt_pkg::OP_WRITE) ? e3.data : sum_sat[31:0];
  assign row_flag = rsat || psat3 || sum_sat[32];

  // stage 4 final fine value
  assign fin_sat = sgt_pkg::sat32(34'(d4) + 34'(a4));

  // valid bits, accumulator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      acc          <= '0;
      rsat         <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= pop;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3 && ((e3.op == sgt_pkg::OP_PROLONG && e3.last) ||
                             e3.op == sgt_pkg::OP_READ);
      result_valid <= v4;
      if (v3 && e3.op == sgt_pkg::OP_PROLONG) begin
        if (e3.last) begin
          acc  <= '0;
          rsat <= 1'b0;
        end else begin
          acc  <= sum_sat[31:0];
          rsat <= row_flag;
        end
      end
    end
  end

  // payload registers, coarse values snoop the stage 3 write
  always_ff @(posedge clk) begin
    if (adv) begin
      e1    <= head;
      byp1  <= s3_wr && head.in_range && head.addr == e3.addr;
      bypv1 <= s3_wdata;

      e2 <= e1;
      p2 <= mul_full[sgt_pkg::PROD_W-1:0];
      c2 <= (s3_wr && e1.in_range && e1.addr == e3.addr) ? s3_wdata : c1;

      e3    <= e2;
      prod3 <= prod_sat[31:0];
      psat3 <= prod_sat[32];
      c3    <= (s3_wr && e2.in_range && e2.addr == e3.addr) ? s3_wdata : c2;

      k4 <= (e3.op == sgt_pkg::OP_READ) ? sgt_pkg::KIND_COARSE : sgt_pkg::KIND_FINE;
      d4 <= e3.data;
      a4 <= sum_sat[31:0];
      f4 <= row_flag;
      c4 <= c3;

      if (k4 == sgt_pkg::KIND_COARSE) begin
        result.result_value <= c4;
        result.saturated    <= 1'b0;
      end else begin
        result.result_value <= fin_sat[31:0];
        result.saturated    <= f4 || fin_sat[32];
      end
      result.result_kind <= k4;
    end
  end

endmodule

`default_nettype wire

[rtl/sparse_grid_transfer_spmv_unit.sv]
// sparse_grid_transfer_spmv_unit: top level of the multigrid transfer unit
// depends on sgt_pkg, sgt_front, sgt_queue, sgt_back
//
// The unit streams the nonzeros of a CSR transfer operator against a 4096 entry Q16.16
// coarse vector held in a single write, single read ram. It sustains one transaction per
// cycle when nothing stalls; a transaction passes the queue, the back pipeline stages and
// the output register before its result appears. The one exception is a prolongation
// nonzero that directly follows, within two transactions, a coarse write or restriction
// to the same coarse entry: the multiply reads the entry early in the pipeline, so that
// nonzero waits in the queue until the pending write reaches the read-modify-write stage.
// A stalled result stops the back pipeline while the front keeps taking transactions
// until its four entry queue fills. Coarse entries read before they are written hold
// no defined value; no clearing pass runs after reset.
`default_nettype none

module sparse_grid_transfer_spmv_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire sgt_pkg::in_item_t item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output sgt_pkg::out_item_t     result
);

  logic               q_push;
  logic               q_pop;
  sgt_pkg::q_entry_t  q_in;
  sgt_pkg::q_entry_t  q_head;
  sgt_pkg::q_status_t q_status;

  // accept and classify
  sgt_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .full       (q_status.full),
    .item_stall (item_stall),
    .push       (q_push),
    .entry      (q_in)
  );

  // decoupling queue
  sgt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .entry_in (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // execution
  sgt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (!q_status.empty),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // a coarse read never reports a clip
  a_coarse_no_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == sgt_pkg::KIND_COARSE |-> !result.saturated)
    else $error("coarse read result flagged as saturated");

  // back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue popped while empty");

  // a lone push grows the queue by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(q_push) && !$past(q_pop) |->
      q_status.count == $past(q_status.count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

[dv/testbench.sv]
// testbench: self-checking bench for the sparse grid transfer unit
// depends on sgt_pkg and sparse_grid_transfer_spmv_unit; reads no files

module testbench;
  import sgt_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 24;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  sparse_grid_transfer_spmv_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // stimulus, shadow state and expected results
  in_item_t           nonzero_stream[$];
  out_item_t          results_due[$];
  logic signed [31:0] coarse_image[COARSE_ENTRIES];
  logic signed [31:0] row_sum;
  bit                 row_clip;
  bit                 written_map[COARSE_ENTRIES];
  int                 written_cols[$];
  int                 recent_cols[$];
  int                 items_total;
  int                 items_taken;
  int                 mismatches;
  int                 quiet_cycles;
  bit                 item_taken;
  int                 send_gap;
  int                 send_calm;
  int                 stall_left;
  int                 stall_calm;

  // clip to the signed 32-bit range, flag any clip
  function automatic logic signed [31:0] clamp32(input longint v, inout bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // q1.16 weight times q16.16 value, rounded half up back to q16.16
  function automatic logic signed [31:0] weighted(input logic [16:0] w,
                                                 input logic signed [31:0] x,
                                                 inout bit clip);
    longint p;
    p = longint'(w) * longint'(x);
    return clamp32((p + 64'sd32768) >>> 16, clip);
  endfunction

  // shadow of the unit: update state, queue any result the transaction causes
  task automatic predict_transfer(input in_item_t t);
    opcode_t            op;
    int                 col;
    bit                 in_range;
    logic signed [31:0] entry;
    logic signed [31:0] prod;
    bit                 clip;
    bit                 end_clip;
    out_item_t          r;
    op       = opcode_t'(t.opcode);
    col      = t.coarse_index;
    in_range = col < COARSE_ENTRIES;
    entry    = in_range ? coarse_image[col] : 32'sd0;
    clip     = 1'b0;
    end_clip = 1'b0;
    r        = '0;
    case (op)
      OP_WRITE: begin
        if (in_range) coarse_image[col] = t.data_value;
      end
      OP_PROLONG: begin
        prod     = weighted(t.weight, entry, clip);
        row_sum  = clamp32(longint'(row_sum) + longint'(prod), clip);
        row_clip = row_clip | clip;
        if (t.last_of_row) begin
          r.result_value = clamp32(longint'(t.data_value) + longint'(row_sum), end_clip);
          r.result_kind  = KIND_FINE;
          r.saturated    = end_clip | row_clip;
          results_due.push_back(r);
          row_sum  = '0;
          row_clip = 1'b0;
        end
      end
      OP_RESTRICT: begin
        if (in_range) begin
          prod = weighted(t.weight, t.data_value, clip);
          coarse_image[col] = clamp32(longint'(entry) + longint'(prod), clip);
        end
      end
      default: begin
        r.result_value = entry;
        r.result_kind  = KIND_COARSE;
        r.saturated    = 1'b0;
        results_due.push_back(r);
      end
    endcase
  endtask

  // append one transaction, keep track of entries that hold a value
  function automatic void queue_item(input opcode_t op, input int col,
                                     input logic [16:0] w,
                                     input logic signed [31:0] d, input bit last);
    in_item_t t;
    t.opcode       = op;
    t.coarse_index = col[11:0];
    t.weight       = w;
    t.data_value   = d;
    t.last_of_row  = last;
    nonzero_stream.push_back(t);
    if (op == OP_WRITE || op == OP_RESTRICT) begin
      recent_cols.push_back(col);
      if (recent_cols.size() > 3) void'(recent_cols.pop_front());
    end
    if (op == OP_WRITE && !written_map[col]) begin
      written_map[col] = 1'b1;
      written_cols.push_back(col);
    end
  endfunction

  // a column that already holds a value, often one just updated
  function automatic int pick_column();
    if (recent_cols.size() > 0 && $urandom_range(0, 99) < 30)
      return recent_cols[$urandom_range(0, recent_cols.size() - 1)];
    return written_cols[$urandom_range(0, written_cols.size() - 1)];
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 90) return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sd2097152;
    if (r < 95) return 32'sh7FFF_FFFF;
    return 32'sh8000_0000;
  endfunction

  function automatic logic [16:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 17'($urandom_range(0, 131071));
    if (r < 80) return 17'($urandom_range(0, 65536));
    if (r < 90) return 17'd65536;
    if (r < 95) return 17'd0;
    return 17'd131071;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // directed opening: extremes, rounding ties, clipping, write then prolong hazards
  task automatic build_directed();
    queue_item(OP_WRITE,    0,    17'd0,      32'sh7FFF_FFFF, 1'b0);
    queue_item(OP_WRITE,    4095, 17'd131071, 32'sh8000_0000, 1'b0);
    queue_item(OP_WRITE,    1,    17'd0,      32'sh0001_0000, 1'b0);
    queue_item(OP_WRITE,    2,    17'd0,      -32'sd1,        1'b1);
    queue_item(OP_READ,     0,    17'd0,      32'sd0,         1'b1);
    queue_item(OP_READ,     4095, 17'd131071, 32'sd0,         1'b0);
    // two-nonzero row with a weight above one and a negative round
    queue_item(OP_PROLONG,  1,    17'd65536,  32'sh1234_5678, 1'b0);
    queue_item(OP_PROLONG,  2,    17'd131071, 32'sd0,         1'b1);
    // product clips
    queue_item(OP_PROLONG,  0,    17'd131071, 32'sd0,         1'b1);
    // accumulator clips, flag held to row end
    queue_item(OP_PROLONG,  0,    17'd65536,  32'sd0,         1'b0);
    queue_item(OP_PROLONG,  0,    17'd65536,  32'sd0,         1'b0);
    queue_item(OP_PROLONG,  4095, 17'd0,      32'sd0,         1'b1);
    // empty row, then clips in the final addition both ways
    queue_item(OP_PROLONG,  1,    17'd0,      32'sh8000_0000, 1'b1);
    queue_item(OP_PROLONG,  1,    17'd65536,  32'sh7FFF_FFFF, 1'b1);
    queue_item(OP_PROLONG,  4095, 17'd65536,  32'sh8000_0000, 1'b1);
    // restriction clipping at both limits, and ties
    queue_item(OP_RESTRICT, 0,    17'd131071, 32'sh7FFF_FFFF, 1'b1);
    queue_item(OP_RESTRICT, 4095, 17'd65536,  32'sh8000_0000, 1'b0);
    queue_item(OP_RESTRICT, 1,    17'd32768,  32'sd3,         1'b1);
    queue_item(OP_RESTRICT, 2,    17'd32768,  -32'sd1,        1'b0);
    queue_item(OP_READ,     0,    17'd0,      32'sd0,         1'b0);
    queue_item(OP_READ,     4095, 17'd0,      32'sd0,         1'b0);
    // prolongation right behind an update of the same entry
    queue_item(OP_WRITE,    3,    17'd0,      32'sh0002_0000, 1'b0);
    queue_item(OP_PROLONG,  3,    17'd65536,  32'sd0,         1'b1);
    queue_item(OP_RESTRICT, 3,    17'd65536,  32'sh0001_0000, 1'b0);
    queue_item(OP_PROLONG,  1,    17'd65536,  32'sd0,         1'b0);
    queue_item(OP_PROLONG,  3,    17'd65536,  32'sd0,         1'b1);
  endtask

  // random part: mostly whole rows, with writes, restrictions and reads between
  task automatic build_random();
    int goal;
    int kind;
    int len;
    goal = nonzero_stream.size() + RANDOM_ITEMS;
    while (nonzero_stream.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(0, 6);
        if (len == 0) begin
          queue_item(OP_PROLONG, pick_column(), 17'd0, pick_value(), 1'b1);
        end else begin
          for (int k = 0; k < len; k++) begin
            // occasional stray transaction inside a row
            if (k > 0 && $urandom_range(0, 99) < 8)
              queue_item(OP_READ, pick_column(), pick_weight(), pick_value(),
                         1'($urandom));
            queue_item(OP_PROLONG, pick_column(), pick_weight(), pick_value(),
                       k == len - 1);
          end
        end
      end else if (kind < 65) begin
        queue_item(OP_WRITE, $urandom_range(0, 4095), pick_weight(), pick_value(),
                   1'($urandom));
      end else if (kind < 85) begin
        queue_item(OP_RESTRICT, pick_column(), pick_weight(), pick_value(),
                   1'($urandom));
      end else begin
        queue_item(OP_READ, pick_column(), pick_weight(), pick_value(), 1'($urandom));
      end
    end
    // close any row left open by the stray transactions
    queue_item(OP_PROLONG, pick_column(), 17'd0, 32'sd0, 1'b1);
  endtask

  // input driver: next transaction once the current one is taken
  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (send_gap > 0) begin
        item_valid <= 1'b0;
        send_gap--;
      end else if (nonzero_stream.size() > 0) begin
        item       <= nonzero_stream.pop_front();
        item_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = idle_span();
          if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(30, 80);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result back pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        if (stall_calm > 0) begin
          stall_calm--;
        end else begin
          stall_left = idle_span();
          if ($urandom_range(0, 199) == 0) stall_calm = $urandom_range(50, 150);
        end
      end
    end
  end

  // monitor: check results, then predict from each accepted transaction
  always @(posedge clk) begin : monitor
    out_item_t want;
    bit        result_taken;
    if (rst) begin
      item_taken = 1'b0;
    end else begin
      result_taken = result_valid && !result_stall;
      if (result_taken) begin
        if (results_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value %h kind %b sat %b",
                     result.result_value, result.result_kind, result.saturated);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (result.result_value !== want.result_value ||
              result.result_kind !== want.result_kind ||
              result.saturated !== want.saturated) begin
            if (mismatches < 10)
              $display("mismatch: expected value %h kind %b sat %b, got %h %b %b",
                       want.result_value, want.result_kind, want.saturated,
                       result.result_value, result.result_kind, result.saturated);
            mismatches++;
          end
        end
      end
      item_taken = item_valid && !item_stall;
      if (item_taken) begin
        predict_transfer(item);
        items_taken++;
      end
      if (item_taken || result_taken) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog on cycles with no transaction
  always @(negedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // sequence: build stimulus, reset, drain, verdict
  initial begin
    row_sum      = '0;
    row_clip     = 1'b0;
    items_taken  = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    item_taken   = 1'b0;
    send_gap     = 0;
    send_calm    = 0;
    stall_left   = 0;
    stall_calm   = 0;
    for (int i = 0; i < COARSE_ENTRIES; i++) begin
      coarse_image[i] = '0;
      written_map[i]  = 1'b0;
    end
    build_directed();
    build_random();
    items_total = nonzero_stream.size();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (items_taken < items_total) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
